@@ rtl/core/nfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// nfrc_pkg
// Shared types, constants and fixed-point helpers of the Newton root classifier
// ----------------------------------------------------------------------------
package nfrc_pkg;

    localparam int NUM_ROOTS   = 5;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int STEPS_W     = 7;
    localparam int UPC_W       = 4;
    localparam int DIV_STEPS   = 88;
    localparam int DIV_CNT_W   = 7;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS   = CFG_IDX_W'(NUM_ROOTS);
    localparam logic [STEPS_W-1:0]   STEPS_RESET = STEPS_W'(16);
    localparam logic [63:0]          FAR_LIMIT   = 64'd100 << 48;

    typedef logic [NUM_ROOTS-1:0][31:0] root_vec_t;

    typedef enum logic [3:0] {
        MS_DR_WR, MS_DI_WI, MS_DR_WI, MS_DI_WR,
        MS_PR_WR, MS_PI_WI, MS_PR_WI, MS_PI_WR,
        MS_PR_DR, MS_PI_DI, MS_PI_DR, MS_PR_DI,
        MS_DR_DR, MS_DI_DI, MS_WR_WR, MS_WI_WI
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
    } acc_op_t;

    typedef enum logic [3:0] {
        WB_NONE, WB_LOAD, WB_INIT, WB_WSAT, WB_WRAW, WB_TR, WB_TI, WB_D,
        WB_P, WB_NR, WB_NI, WB_DEN, WB_ZR, WB_ZI, WB_BEST, WB_OUT
    } wb_op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_INIT, ST_ROOT, ST_NUM, ST_DIV_RE, ST_DIV_IM, ST_DIST, ST_DONE
    } state_t;

    typedef struct packed {
        mul_sel_t         mul;
        acc_op_t          acc;
        wb_op_t           wb;
        logic             div_start;
        logic             div_imag;
        logic [IDX_W-1:0] k;
    } cmd_t;

    typedef struct packed {
        logic d_zero;
        logic div_done;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    // floor to q8.24 and saturate
    function automatic logic signed [31:0] sat_shift(input logic signed [65:0] v);
        logic signed [65:0] s;
        s = v >>> 24;
        if ((&s[65:31]) || !(|s[65:31])) begin
            return s[31:0];
        end
        return s[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    function automatic logic signed [31:0] q412_to_q824(input logic [15:0] h);
        return {{4{h[15]}}, h, 12'b0};
    endfunction

    function automatic rgb_t root_colour(input logic [IDX_W-1:0] k);
        rgb_t c;
        case (k)
            3'd0:    c = '{blue: 8'd206, green: 8'd161, red: 8'd30};
            3'd1:    c = '{blue: 8'd141, green: 8'd83,  red: 8'd56};
            3'd2:    c = '{blue: 8'd87,  green: 8'd12,  red: 8'd73};
            3'd3:    c = '{blue: 8'd97,  green: 8'd186, red: 8'd87};
            3'd4:    c = '{blue: 8'd142, green: 8'd133, red: 8'd24};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/nfrc_divider.sv @@
// ----------------------------------------------------------------------------
// nfrc_divider
// Bit-serial restoring divider: (num * 2^24) / den, signed saturated result
// ----------------------------------------------------------------------------
module nfrc_divider import nfrc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [63:0]        num,
    input  logic               neg,
    input  logic [63:0]        den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic [87:0]          dvd_reg;
    logic [63:0]          rem_reg;
    logic [63:0]          den_reg;
    logic [31:0]          q_reg;
    logic                 big_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [64:0] rem2;
    logic        ge;
    logic [64:0] diff;

    assign rem2 = {rem_reg, dvd_reg[87]};
    assign ge   = rem2 >= {1'b0, den_reg};
    assign diff = rem2 - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num, 24'b0};
            rem_reg <= '0;
            den_reg <= den;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= neg;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[86:0], 1'b0};
            rem_reg <= ge ? diff[63:0] : rem2[63:0];
            // quotient past 32 bits saturates whatever follows
            big_reg <= big_reg | q_reg[31];
            q_reg   <= {q_reg[30:0], ge};
        end
    end

    always_comb begin
        if (big_reg || q_reg[31]) begin
            quot = neg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);
        end
    end

    assign done = done_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

endmodule

@@ rtl/core/nfrc_datapath.sv @@
// ----------------------------------------------------------------------------
// nfrc_datapath
// Shared multiplier, accumulator, complex state registers and result register
// ----------------------------------------------------------------------------
module nfrc_datapath import nfrc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  root_vec_t   roots,
    input  logic [31:0] in_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    logic signed [31:0] zr_reg, zi_reg, pr_reg, pi_reg, dr_reg, di_reg;
    logic signed [31:0] tr_reg, ti_reg;
    logic signed [32:0] wr_reg, wi_reg;
    logic signed [65:0] prod_reg, acc_reg;
    logic [63:0]        nr_reg, ni_reg, den_reg, best_reg;
    logic               negr_reg, negi_reg;
    logic [IDX_W-1:0]   best_k_reg, out_k_reg;
    logic               m_valid_reg;

    logic signed [32:0] op_a, op_b;
    logic signed [31:0] rt_re, rt_im;
    logic signed [32:0] dz_re, dz_im;
    logic [65:0]        acc_mag;
    logic               div_done;
    logic signed [31:0] quot;
    rgb_t               colour;

    assign rt_re = q412_to_q824(roots[cmd.k][31:16]);
    assign rt_im = q412_to_q824(roots[cmd.k][15:0]);
    assign dz_re = {zr_reg[31], zr_reg} - {rt_re[31], rt_re};
    assign dz_im = {zi_reg[31], zi_reg} - {rt_im[31], rt_im};
    assign acc_mag = acc_reg[65] ? 66'(-acc_reg) : 66'(acc_reg);

    always_comb begin
        unique case (cmd.mul)
            MS_DR_WR: begin op_a = {dr_reg[31], dr_reg}; op_b = wr_reg; end
            MS_DI_WI: begin op_a = {di_reg[31], di_reg}; op_b = wi_reg; end
            MS_DR_WI: begin op_a = {dr_reg[31], dr_reg}; op_b = wi_reg; end
            MS_DI_WR: begin op_a = {di_reg[31], di_reg}; op_b = wr_reg; end
            MS_PR_WR: begin op_a = {pr_reg[31], pr_reg}; op_b = wr_reg; end
            MS_PI_WI: begin op_a = {pi_reg[31], pi_reg}; op_b = wi_reg; end
            MS_PR_WI: begin op_a = {pr_reg[31], pr_reg}; op_b = wi_reg; end
            MS_PI_WR: begin op_a = {pi_reg[31], pi_reg}; op_b = wr_reg; end
            MS_PR_DR: begin op_a = {pr_reg[31], pr_reg}; op_b = {dr_reg[31], dr_reg}; end
            MS_PI_DI: begin op_a = {pi_reg[31], pi_reg}; op_b = {di_reg[31], di_reg}; end
            MS_PI_DR: begin op_a = {pi_reg[31], pi_reg}; op_b = {dr_reg[31], dr_reg}; end
            MS_PR_DI: begin op_a = {pr_reg[31], pr_reg}; op_b = {di_reg[31], di_reg}; end
            MS_DR_DR: begin op_a = {dr_reg[31], dr_reg}; op_b = {dr_reg[31], dr_reg}; end
            MS_DI_DI: begin op_a = {di_reg[31], di_reg}; op_b = {di_reg[31], di_reg}; end
            MS_WR_WR: begin op_a = wr_reg; op_b = wr_reg; end
            MS_WI_WI: begin op_a = wi_reg; op_b = wi_reg; end
            default:  begin op_a = '0; op_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        case (cmd.acc)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            ACC_SUB:  acc_reg <= acc_reg - prod_reg;
            default:  acc_reg <= acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.wb)
            WB_LOAD: begin
                zr_reg   <= q412_to_q824(in_data[15:0]);
                zi_reg   <= q412_to_q824(in_data[31:16]);
                best_reg <= FAR_LIMIT;
                best_k_reg <= '0;
            end
            WB_INIT: begin
                pr_reg <= 32'sh0100_0000;
                pi_reg <= '0;
                dr_reg <= '0;
                di_reg <= '0;
            end
            WB_WSAT: begin
                wr_reg <= 33'(sat33(dz_re));
                wi_reg <= 33'(sat33(dz_im));
            end
            WB_WRAW: begin
                wr_reg <= dz_re;
                wi_reg <= dz_im;
            end
            WB_TR:  tr_reg <= sat_shift(acc_reg);
            WB_TI:  ti_reg <= sat_shift(acc_reg);
            WB_D: begin
                dr_reg <= sat33({tr_reg[31], tr_reg} + {pr_reg[31], pr_reg});
                di_reg <= sat33({ti_reg[31], ti_reg} + {pi_reg[31], pi_reg});
            end
            WB_P: begin
                pr_reg <= tr_reg;
                pi_reg <= ti_reg;
            end
            WB_NR: begin
                nr_reg   <= acc_mag[63:0];
                negr_reg <= acc_reg[65];
            end
            WB_NI: begin
                ni_reg   <= acc_mag[63:0];
                negi_reg <= acc_reg[65];
            end
            WB_DEN: den_reg <= acc_reg[63:0];
            WB_ZR:  zr_reg  <= sat33({zr_reg[31], zr_reg} - {quot[31], quot});
            WB_ZI:  zi_reg  <= sat33({zi_reg[31], zi_reg} - {quot[31], quot});
            WB_BEST: begin
                // strict compare keeps the lower index on a tie
                if ($unsigned(acc_reg) < {2'b0, best_reg}) begin
                    best_reg   <= acc_reg[63:0];
                    best_k_reg <= cmd.k;
                end
            end
            WB_OUT:  out_k_reg <= best_k_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.wb == WB_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    nfrc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (cmd.div_imag ? ni_reg : nr_reg),
        .neg     (cmd.div_imag ? negi_reg : negr_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (quot)
    );

    assign colour   = root_colour(out_k_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, colour.blue, colour.green, colour.red, out_k_reg};

    assign status.d_zero   = (dr_reg == '0) && (di_reg == '0);
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_tready;

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wb == WB_OUT) |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten before its beat was taken");

endmodule

@@ rtl/core/nfrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// nfrc_ctrl
// Sequencer: Newton steps over all roots, division, nearest-root search
// ----------------------------------------------------------------------------
module nfrc_ctrl import nfrc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [STEPS_W-1:0] steps,
    input  status_t            status,
    output cmd_t               cmd
);

    state_t             state_reg, state_next;
    logic [UPC_W-1:0]   upc_reg, upc_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [STEPS_W-1:0] it_reg, it_next;

    logic last_root;
    assign last_root = (k_reg == IDX_W'(NUM_ROOTS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            upc_reg   <= '0;
            k_reg     <= '0;
            it_reg    <= '0;
        end else begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
            k_reg     <= k_next;
            it_reg    <= it_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        upc_next      = upc_reg;
        k_next        = k_reg;
        it_next       = it_reg;
        cmd.mul       = MS_DR_WR;
        cmd.acc       = ACC_HOLD;
        cmd.wb        = WB_NONE;
        cmd.div_start = 1'b0;
        cmd.div_imag  = 1'b0;
        cmd.k         = k_reg;

        unique case (state_reg)
            ST_IDLE: begin
                it_next  = '0;
                k_next   = '0;
                upc_next = '0;
                if (s_tvalid) begin
                    cmd.wb     = WB_LOAD;
                    state_next = (steps == '0) ? ST_DIST : ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.wb     = WB_INIT;
                k_next     = '0;
                upc_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                upc_next = upc_reg + 1'b1;
                unique case (upc_reg)
                    4'd0:  cmd.wb = WB_WSAT;
                    4'd1:  cmd.mul = MS_DR_WR;
                    4'd2:  begin cmd.mul = MS_DI_WI; cmd.acc = ACC_LOAD; end
                    4'd3:  begin cmd.mul = MS_DR_WI; cmd.acc = ACC_SUB; end
                    4'd4:  begin cmd.mul = MS_DI_WR; cmd.acc = ACC_LOAD; cmd.wb = WB_TR; end
                    4'd5:  begin cmd.mul = MS_PR_WR; cmd.acc = ACC_ADD; end
                    4'd6:  begin cmd.mul = MS_PI_WI; cmd.acc = ACC_LOAD; cmd.wb = WB_TI; end
                    4'd7:  begin cmd.mul = MS_PR_WI; cmd.acc = ACC_SUB; cmd.wb = WB_D; end
                    4'd8:  begin cmd.mul = MS_PI_WR; cmd.acc = ACC_LOAD; cmd.wb = WB_TR; end
                    4'd9:  cmd.acc = ACC_ADD;
                    4'd10: cmd.wb = WB_TI;
                    default: begin
                        cmd.wb   = WB_P;
                        upc_next = '0;
                        if (!last_root) begin
                            k_next = k_reg + 1'b1;
                        end else if (!status.d_zero) begin
                            state_next = ST_NUM;
                        end else begin
                            // zero derivative: z held for this step
                            it_next    = it_reg + 1'b1;
                            k_next     = '0;
                            state_next = (it_reg + 1'b1 < steps) ? ST_INIT : ST_DIST;
                        end
                    end
                endcase
            end
            ST_NUM: begin
                upc_next = upc_reg + 1'b1;
                unique case (upc_reg)
                    4'd0: cmd.mul = MS_PR_DR;
                    4'd1: begin cmd.mul = MS_PI_DI; cmd.acc = ACC_LOAD; end
                    4'd2: begin cmd.mul = MS_PI_DR; cmd.acc = ACC_ADD; end
                    4'd3: begin cmd.mul = MS_PR_DI; cmd.acc = ACC_LOAD; cmd.wb = WB_NR; end
                    4'd4: begin cmd.mul = MS_DR_DR; cmd.acc = ACC_SUB; end
                    4'd5: begin cmd.mul = MS_DI_DI; cmd.acc = ACC_LOAD; cmd.wb = WB_NI; end
                    4'd6: cmd.acc = ACC_ADD;
                    default: begin
                        cmd.wb     = WB_DEN;
                        upc_next   = '0;
                        state_next = ST_DIV_RE;
                    end
                endcase
            end
            ST_DIV_RE: begin
                if (upc_reg == '0) begin
                    cmd.div_start = 1'b1;
                    upc_next      = 4'd1;
                end else if (status.div_done) begin
                    cmd.wb     = WB_ZR;
                    upc_next   = '0;
                    state_next = ST_DIV_IM;
                end
            end
            ST_DIV_IM: begin
                cmd.div_imag = 1'b1;
                if (upc_reg == '0) begin
                    cmd.div_start = 1'b1;
                    upc_next      = 4'd1;
                end else if (status.div_done) begin
                    cmd.wb     = WB_ZI;
                    upc_next   = '0;
                    k_next     = '0;
                    it_next    = it_reg + 1'b1;
                    state_next = (it_reg + 1'b1 < steps) ? ST_INIT : ST_DIST;
                end
            end
            ST_DIST: begin
                upc_next = upc_reg + 1'b1;
                unique case (upc_reg)
                    4'd0: cmd.wb = WB_WRAW;
                    4'd1: cmd.mul = MS_WR_WR;
                    4'd2: begin cmd.mul = MS_WI_WI; cmd.acc = ACC_LOAD; end
                    4'd3: cmd.acc = ACC_ADD;
                    default: begin
                        cmd.wb   = WB_BEST;
                        upc_next = '0;
                        if (last_root) begin
                            state_next = ST_DONE;
                        end else begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                endcase
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.wb     = WB_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    a_div_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (state_reg == ST_DIV_RE || state_reg == ST_DIV_IM))
        else $error("division started outside a division phase");

    a_k_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg < IDX_W'(NUM_ROOTS))
        else $error("root counter past the last root");

    a_out_leaves_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wb == WB_OUT) |=> (state_reg == ST_IDLE))
        else $error("result written without returning to idle");

endmodule

@@ rtl/core/newton_fractal_root_classifier_core.sv @@
// ----------------------------------------------------------------------------
// newton_fractal_root_classifier_core
// Newton iteration on a monic quintic and nearest-root colour lookup
// ----------------------------------------------------------------------------
// channel   dir  width  contents
// s_        in   32     start point, one beat per pixel
// m_        out  32     root index and colour, one beat per pixel
// cfg_      in   32     five root registers, step count
//
// each newton step runs on the shared 33x33 multiplier and the bit-serial
// divider (88 quotient bits per component); a step with a zero derivative
// skips the division
// reset is synchronous and active low; root registers clear, steps go to 16
// the next start point is taken while the previous result waits on m_tready
// ----------------------------------------------------------------------------
module newton_fractal_root_classifier_core import nfrc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // start_real, start_imag
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // root_index, red, green, blue
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    root_vec_t          roots_reg;
    logic [STEPS_W-1:0] steps_reg;
    cmd_t               cmd;
    status_t            status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roots_reg <= '0;
            steps_reg <= STEPS_RESET;
        end else if (cfg_wen) begin
            if (cfg_index < CFG_IDX_W'(NUM_ROOTS)) begin
                roots_reg[cfg_index] <= cfg_wdata;
            end else if (cfg_index == REG_STEPS) begin
                steps_reg <= cfg_wdata[STEPS_W-1:0];
            end
        end
    end

    nfrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .steps    (steps_reg),
        .status   (status),
        .cmd      (cmd)
    );

    nfrc_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .roots    (roots_reg),
        .in_data  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the Newton fractal root classifier core
// Random and directed start points under several root sets and step counts.
// A scoreboard class runs the fixed-point Newton iteration itself and checks
// each root index and colour beat in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    import nfrc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [2:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    class pixel_colour_board;
        logic [31:0] roots [NUM_ROOTS];
        logic [6:0]  steps;
        pixel_t      pending_px [$];
        int          errors;

        function new();
            foreach (roots[k]) roots[k] = '0;
            steps  = STEPS_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx < REG_STEPS) roots[idx] = val;
            else if (idx == REG_STEPS) steps = val[6:0];
        endfunction

        function int sat_w(logic signed [65:0] v);
            if (v > 66'sd2147483647) return 32'h7fff_ffff;
            if (v < -66'sd2147483648) return 32'h8000_0000;
            return v[31:0];
        endfunction

        function int half_q(logic [15:0] h);
            int t;
            t = $signed(h);
            return t * 4096;
        endfunction

        function int floor_sum(longint x, longint y);
            logic signed [65:0] s;
            s = x;
            s = s + y;
            return sat_w(s >>> 24);
        endfunction

        // truncating quotient of n * 2^24 / den, saturated
        function int quot(logic signed [65:0] n, longint unsigned den);
            logic [65:0] mag;
            logic [89:0] q;
            bit neg;
            neg = n < 0;
            mag = neg ? -n : n;
            q = {mag, 24'b0} / den;
            if (!neg) return (q >= 90'd2147483647) ? 32'h7fff_ffff : int'(q[31:0]);
            return (q >= 90'd2147483648) ? 32'h8000_0000 : -int'(q[31:0]);
        endfunction

        function pixel_t classify(logic [31:0] pt);
            int zr, zi, pr, pi, dr, di, wr, wi, tr, ti, qr, qi;
            longint unsigned den;
            logic signed [65:0] nr, ni;
            longint dx, dy;
            logic [63:0] ux, uy, best;
            logic [64:0] d;
            int best_k;
            logic [7:0] tab [8][3];
            pixel_t px;
            tab = '{'{30, 161, 206}, '{56, 83, 141}, '{73, 12, 87}, '{87, 186, 97},
                    '{24, 133, 142}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}};
            zr = half_q(pt[15:0]);
            zi = half_q(pt[31:16]);
            for (int it = 0; it < steps; it++) begin
                pr = 1 << 24; pi = 0; dr = 0; di = 0;
                for (int k = 0; k < NUM_ROOTS; k++) begin
                    wr = sat_w(longint'(zr) - half_q(roots[k][31:16]));
                    wi = sat_w(longint'(zi) - half_q(roots[k][15:0]));
                    tr = floor_sum(longint'(dr) * wr, -(longint'(di) * wi));
                    ti = floor_sum(longint'(dr) * wi, longint'(di) * wr);
                    dr = sat_w(longint'(tr) + pr);
                    di = sat_w(longint'(ti) + pi);
                    tr = floor_sum(longint'(pr) * wr, -(longint'(pi) * wi));
                    ti = floor_sum(longint'(pr) * wi, longint'(pi) * wr);
                    pr = tr;
                    pi = ti;
                end
                den = longint'(dr) * dr + longint'(di) * di;
                if (den == 0) continue;   // zero derivative holds z
                nr = longint'(pr) * dr;
                nr = nr + longint'(pi) * di;
                ni = longint'(pi) * dr;
                ni = ni - longint'(pr) * di;
                qr = quot(nr, den);
                qi = quot(ni, den);
                zr = sat_w(longint'(zr) - qr);
                zi = sat_w(longint'(zi) - qi);
            end
            best = FAR_LIMIT;
            best_k = 0;
            for (int k = 0; k < NUM_ROOTS; k++) begin
                dx = longint'(zr) - half_q(roots[k][31:16]);
                dy = longint'(zi) - half_q(roots[k][15:0]);
                ux = dx < 0 ? -dx : dx;
                uy = dy < 0 ? -dy : dy;
                d = ux * ux + uy * uy;
                if (d[64]) d = {1'b0, {64{1'b1}}};
                if (d[63:0] < best) begin
                    best = d[63:0];
                    best_k = k;
                end
            end
            px.index = best_k[2:0];
            px.red   = tab[best_k][0];
            px.green = tab[best_k][1];
            px.blue  = tab[best_k][2];
            return px;
        endfunction

        function void note_point(logic [31:0] pt);
            pending_px.push_back(classify(pt));
        endfunction

        function void check_pixel(logic [31:0] data);
            pixel_t e;
            if (pending_px.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", data);
                return;
            end
            e = pending_px.pop_front();
            if (data[2:0] !== e.index || data[10:3] !== e.red || data[18:11] !== e.green
                    || data[26:19] !== e.blue || data[31:27] !== 5'd0) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp idx %0d rgb %0d/%0d/%0d, got idx %0d rgb %0d/%0d/%0d pad %h",
                             e.index, e.red, e.green, e.blue, data[2:0], data[10:3],
                             data[18:11], data[26:19], data[31:27]);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;

    pixel_colour_board board = new();
    bit calm = 1'b0;
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    newton_fractal_root_classifier_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // monitors, result-side stalls and the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_point(s_tdata);
            if (m_tvalid && m_tready) board.check_pixel(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("newton_fractal_root_classifier_core regression: fail");
                $finish;
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 15);
    end

    task automatic send_point(logic [31:0] pt);
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        do @(posedge aclk); while (!s_tready);
        if (!calm && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_px.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        board.write_reg(idx, val);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pack_pt(logic [15:0] re, logic [15:0] im);
        return {im, re};
    endfunction

    // roots near the unit pentagon or fully random
    task automatic load_roots(bit wild);
        logic [31:0] v;
        logic [15:0] pent_re [5];
        logic [15:0] pent_im [5];
        pent_re = '{16'h1000, 16'h04f2, 16'hf30f, 16'hf30f, 16'h04f2};
        pent_im = '{16'h0000, 16'h0f37, 16'h0968, 16'hf698, 16'hf0c9};
        for (int k = 0; k < NUM_ROOTS; k++) begin
            if (wild) v = $urandom();
            else v = {pent_re[k] + 16'($urandom_range(0, 1023)) - 16'd512,
                      pent_im[k] + 16'($urandom_range(0, 1023)) - 16'd512};
            write_reg(REG_ROOT0 + CFG_IDX_W'(k), v);
        end
    endtask

    task automatic random_points(int n);
        logic [31:0] r;
        int k;
        for (int i = 0; i < n; i++) begin
            r = $urandom();
            if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(0, NUM_ROOTS - 1);
                r = {board.roots[k][15:0] + 16'($urandom_range(0, 255)) - 16'd128,
                     board.roots[k][31:16] + 16'($urandom_range(0, 255)) - 16'd128};
            end else if ($urandom_range(0, 1) == 0) begin
                r = {16'($signed(r[31:16]) >>> 2), 16'($signed(r[15:0]) >>> 2)};
            end
            send_point(r);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all roots at zero after reset: the origin has a zero derivative
        send_point(pack_pt(16'h0000, 16'h0000));
        send_point(pack_pt(16'h7fff, 16'h7fff));
        send_point(pack_pt(16'h8000, 16'h8000));
        send_point(pack_pt(16'h8000, 16'h7fff));
        drain();

        // no iteration, all roots at one far point: only the start point on it lies within range
        for (int k = 0; k < NUM_ROOTS; k++) write_reg(REG_ROOT0 + CFG_IDX_W'(k), 32'h7e00_7e00);
        write_reg(REG_STEPS, 32'd0);
        write_reg(REG_UNUSED, 32'hffff_ffff);
        send_point(pack_pt(16'h8000, 16'h8000));
        send_point(pack_pt(16'h7e00, 16'h7e00));
        send_point(pack_pt(16'h0000, 16'h0000));
        drain();

        // duplicate roots: ties keep the lower index
        write_reg(REG_ROOT0, 32'h1000_0000);
        write_reg(REG_ROOT0 + 3'd1, 32'hf000_0000);
        write_reg(REG_ROOT0 + 3'd2, 32'h1000_0000);
        write_reg(REG_ROOT0 + 3'd3, 32'h0000_1000);
        write_reg(REG_ROOT0 + 3'd4, 32'h0000_f000);
        write_reg(REG_STEPS, 32'd1);
        send_point(pack_pt(16'h1000, 16'h0000));
        send_point(pack_pt(16'h0000, 16'h0000));
        send_point(pack_pt(16'hf000, 16'h0000));
        send_point(pack_pt(16'h0000, 16'hf000));
        send_point(pack_pt(16'h0800, 16'h0800));
        drain();

        // step counts of 64 and the largest encodable, few points
        load_roots(1'b0);
        write_reg(REG_STEPS, 32'd64);
        send_point(pack_pt(16'h0123, 16'hfabc));
        send_point(pack_pt(16'h7fff, 16'h8000));
        random_points(3);
        drain();
        write_reg(REG_STEPS, 32'd127);
        random_points(2);
        drain();

        for (int ph = 0; ph < 20; ph++) begin
            load_roots(ph % 3 == 2);
            write_reg(REG_STEPS, (ph % 5 == 4) ? 32'd0 : 32'($urandom_range(1, 4)));
            calm = (ph == 7);
            random_points(89);
            drain();
        end
        calm = 1'b0;

        if (board.errors == 0)
            $display("newton_fractal_root_classifier_core regression: pass");
        else
            $display("newton_fractal_root_classifier_core regression: fail");
        $finish;
    end
endmodule

@@ newton_fractal_root_classifier_core.f @@
rtl/core/nfrc_pkg.sv
rtl/core/nfrc_divider.sv
rtl/core/nfrc_datapath.sv
rtl/core/nfrc_ctrl.sv
rtl/core/newton_fractal_root_classifier_core.sv
tb/sv/tb.sv
